### hdl/tle_pkg.sv
// ----------------------------------------------------------------------------
// Terminal line editor package
// Shared types, codes and constants of the line editor with word wrap.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

	localparam int CHAR_W   = 8;
	localparam int ACTION_W = 3;
	localparam int COUNT_W  = 6;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam int LINE_WIDTH_DEF = 40;

	// Result actions
	localparam logic [ACTION_W-1:0] ACT_ECHO    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ERASE   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_BELL    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_NEWLINE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_END     = 3'd4;

	// Fixed character codes
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;
	localparam logic [CHAR_W-1:0] CH_EOT    = 8'd4;
	localparam logic [CHAR_W-1:0] CH_BELL   = 8'd7;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'd10;
	localparam logic [CHAR_W-1:0] CH_WERASE = 8'd23;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
	localparam logic [CHAR_W-1:0] CH_TILDE  = 8'd126;

	// Register map: the register index is paddr[2]
	localparam int             REG_SEL_BIT    = 2;
	localparam logic           REG_ERASE_CHAR = 1'b0;
	localparam logic           REG_KILL_CHAR  = 1'b1;
	localparam logic [CHAR_W-1:0] ERASE_CHAR_RST = 8'd127;
	localparam logic [CHAR_W-1:0] KILL_CHAR_RST  = 8'd21;

	typedef struct packed {
		logic [CHAR_W-1:0] erase_char;
		logic [CHAR_W-1:0] kill_char;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/tle_if.sv
// ----------------------------------------------------------------------------
// Terminal line editor channels
// Valid/ready channels for typed bytes and for echo results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tle_key_if;
	logic                       valid;
	logic                       ready;
	logic [tle_pkg::CHAR_W-1:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface tle_echo_if;
	logic                         valid;
	logic                         ready;
	logic [tle_pkg::ACTION_W-1:0] action;
	logic [tle_pkg::CHAR_W-1:0]   out_char;
	logic [tle_pkg::COUNT_W-1:0]  erase_count;
	logic                         last_of_run;

	modport source (output valid, output action, output out_char, output erase_count,
		output last_of_run, input ready);
	modport sink   (input valid, input action, input out_char, input erase_count,
		input last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/tle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/tle_cfg.sv
// ----------------------------------------------------------------------------
// Terminal line editor configuration registers
// APB-style register file holding the erase and kill characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tle_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [tle_pkg::PDATA_W-1:0]  pwdata,
	output logic      [tle_pkg::PDATA_W-1:0]  prdata,
	output tle_pkg::cfg_t                     cfg
);

	tle_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic          reg_sel;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[tle_pkg::REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.erase_char <= tle_pkg::ERASE_CHAR_RST;
			cfg_q.kill_char  <= tle_pkg::KILL_CHAR_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				tle_pkg::REG_ERASE_CHAR: cfg_q.erase_char <= pwdata[tle_pkg::CHAR_W-1:0];
				tle_pkg::REG_KILL_CHAR:  cfg_q.kill_char  <= pwdata[tle_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			tle_pkg::REG_ERASE_CHAR: prdata[tle_pkg::CHAR_W-1:0] = cfg_q.erase_char;
			tle_pkg::REG_KILL_CHAR:  prdata[tle_pkg::CHAR_W-1:0] = cfg_q.kill_char;
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/terminal_line_editor_wrap_core.sv
// ----------------------------------------------------------------------------
// Terminal line editor with word wrap
// Line discipline that turns typed bytes into runs of echo actions.
// ----------------------------------------------------------------------------
// Each typed byte on the key channel produces zero or more result beats on the
// echo channel; the final beat of a byte carries last_of_run. The key channel
// is ready only while the sequencer is idle. A plain byte (echo, bell, newline,
// kill, erase, end of session) is decoded in the idle state and then loaded
// into the result register. Word erase scans the line buffer backward with a
// read state and a check state per examined character. A printable byte on a
// full line searches backward for the last space in the same way, then copies
// each character of the wrapped word with a read, a write and an emit state,
// besides the erase, newline and final echo. These steps are set by the line
// buffer with its registered read and by the one result register; stalls on the
// echo channel add to them. The line buffer needs no initialization after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_editor_wrap_core #(
	parameter int LINE_WIDTH = tle_pkg::LINE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tle_key_if.sink                           key,
	tle_echo_if.source                        echo,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tle_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [tle_pkg::PDATA_W-1:0]  pwdata,
	output logic      [tle_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	localparam int LW = $clog2(LINE_WIDTH + 1);
	localparam int AW = $clog2(LINE_WIDTH);
	localparam int CW = tle_pkg::CHAR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_WS_RD, S_WS_CHK, S_FS_RD, S_FS_CHK,
		S_NL, S_CP_RD, S_CP_WR, S_PUT
	} state_t;

	typedef enum logic [2:0] {
		K_END, K_WERASE, K_NL, K_KILL, K_ERASE, K_BELL, K_PUT, K_WRAP
	} kind_t;

	tle_pkg::cfg_t cfg;

	state_t state_q, after_q;
	kind_t  kind;

	logic [LW-1:0] len_q, pos_q, cnt_q, wlen_q, k_q, src_q;
	logic          word_q;
	logic [CW-1:0] c_q;

	logic [tle_pkg::ACTION_W-1:0] pend_act_q, oact_q;
	logic [CW-1:0]                pend_char_q, ochar_q;
	logic [tle_pkg::COUNT_W-1:0]  pend_cnt_q, ocnt_q;
	logic                         pend_last_q, olast_q, ov_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata;

	logic          slot_free;
	logic          emit_go;
	logic          is_space;
	logic          line_full;
	logic [LW-1:0] pos_dec;
	logic [LW-1:0] cnt_inc;
	logic [LW-1:0] wlen_next;
	logic [CW-1:0] c_in;

	tle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	tle_ram #(
		.WIDTH (CW),
		.DEPTH (LINE_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign c_in      = key.in_char;
	assign slot_free = !ov_q || echo.ready;
	assign emit_go   = (state_q == S_EMIT) && slot_free;
	assign line_full = (len_q == LW'(LINE_WIDTH));

	// Shared scan unit: one space compare on the buffer read data, one
	// position decrement and one count increment.
	assign is_space  = (ram_rdata == tle_pkg::CH_SPACE);
	assign pos_dec   = pos_q - LW'(1);
	assign cnt_inc   = cnt_q + LW'(1);
	assign wlen_next = LW'(LINE_WIDTH) - pos_q;

	always_comb begin
		priority if (c_in == tle_pkg::CH_EOT && len_q == '0) begin
			kind = K_END;
		end else if (c_in == tle_pkg::CH_WERASE) begin
			kind = K_WERASE;
		end else if (c_in == tle_pkg::CH_NL) begin
			kind = K_NL;
		end else if (c_in == cfg.kill_char) begin
			kind = K_KILL;
		end else if (c_in == cfg.erase_char) begin
			kind = K_ERASE;
		end else if (c_in < tle_pkg::CH_SPACE || c_in > tle_pkg::CH_TILDE) begin
			kind = K_BELL;
		end else if (!line_full) begin
			kind = K_PUT;
		end else begin
			kind = K_WRAP;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = c_q;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_we    = key.valid && kind == K_PUT;
				ram_waddr = AW'(len_q);
				ram_wdata = c_in;
			end
			S_WS_RD, S_FS_RD: ram_raddr = AW'(pos_dec);
			S_CP_RD:          ram_raddr = AW'(src_q + k_q);
			S_CP_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(k_q);
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(wlen_q);
				ram_wdata = c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			len_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && echo.ready && !emit_go) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (key.valid) begin
					c_q         <= c_in;
					after_q     <= S_IDLE;
					pend_last_q <= 1'b1;
					unique case (kind)
						K_END: begin
							pend_act_q  <= tle_pkg::ACT_END;
							pend_char_q <= tle_pkg::CH_NUL;
							pend_cnt_q  <= '0;
							state_q     <= S_EMIT;
						end
						K_WERASE: begin
							pos_q   <= len_q;
							cnt_q   <= '0;
							word_q  <= 1'b0;
							state_q <= (len_q == '0) ? S_IDLE : S_WS_RD;
						end
						K_NL: begin
							len_q       <= '0;
							pend_act_q  <= tle_pkg::ACT_NEWLINE;
							pend_char_q <= tle_pkg::CH_NL;
							pend_cnt_q  <= '0;
							state_q     <= S_EMIT;
						end
						K_KILL: if (len_q != '0) begin
							len_q       <= '0;
							pend_act_q  <= tle_pkg::ACT_ERASE;
							pend_char_q <= tle_pkg::CH_NUL;
							pend_cnt_q  <= tle_pkg::COUNT_W'(len_q);
							state_q     <= S_EMIT;
						end
						K_ERASE: if (len_q != '0) begin
							len_q       <= len_q - LW'(1);
							pend_act_q  <= tle_pkg::ACT_ERASE;
							pend_char_q <= tle_pkg::CH_NUL;
							pend_cnt_q  <= tle_pkg::COUNT_W'(1);
							state_q     <= S_EMIT;
						end
						K_BELL: begin
							pend_act_q  <= tle_pkg::ACT_BELL;
							pend_char_q <= tle_pkg::CH_BELL;
							pend_cnt_q  <= '0;
							state_q     <= S_EMIT;
						end
						K_PUT: begin
							len_q       <= len_q + LW'(1);
							pend_act_q  <= tle_pkg::ACT_ECHO;
							pend_char_q <= c_in;
							pend_cnt_q  <= '0;
							state_q     <= S_EMIT;
						end
						K_WRAP: begin
							pos_q   <= len_q;
							state_q <= S_FS_RD;
						end
						default: ;
					endcase
				end
				S_EMIT: if (slot_free) begin
					ov_q    <= 1'b1;
					oact_q  <= pend_act_q;
					ochar_q <= pend_char_q;
					ocnt_q  <= pend_cnt_q;
					olast_q <= pend_last_q;
					state_q <= after_q;
				end
				S_WS_RD: state_q <= S_WS_CHK;
				S_WS_CHK: begin
					pend_act_q  <= tle_pkg::ACT_ERASE;
					pend_char_q <= tle_pkg::CH_NUL;
					pend_last_q <= 1'b1;
					after_q     <= S_IDLE;
					// Trailing spaces go first; the first space after the word ends the scan.
					if (word_q && is_space) begin
						len_q      <= pos_q;
						pend_cnt_q <= tle_pkg::COUNT_W'(cnt_q);
						state_q    <= S_EMIT;
					end else begin
						pos_q <= pos_dec;
						cnt_q <= cnt_inc;
						if (!is_space) begin
							word_q <= 1'b1;
						end
						if (pos_dec == '0) begin
							len_q      <= pos_dec;
							pend_cnt_q <= tle_pkg::COUNT_W'(cnt_inc);
							state_q    <= S_EMIT;
						end else begin
							state_q <= S_WS_RD;
						end
					end
				end
				S_FS_RD: state_q <= S_FS_CHK;
				S_FS_CHK: begin
					k_q <= '0;
					if (is_space) begin
						src_q  <= pos_q;
						wlen_q <= wlen_next;
						if (wlen_next != '0) begin
							pend_act_q  <= tle_pkg::ACT_ERASE;
							pend_char_q <= tle_pkg::CH_NUL;
							pend_cnt_q  <= tle_pkg::COUNT_W'(wlen_next);
							pend_last_q <= 1'b0;
							after_q     <= S_NL;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_NL;
						end
					end else begin
						pos_q <= pos_dec;
						if (pos_dec == '0) begin
							// No space on the full line: nothing moves to the new line.
							wlen_q  <= '0;
							src_q   <= '0;
							state_q <= S_NL;
						end else begin
							state_q <= S_FS_RD;
						end
					end
				end
				S_NL: begin
					pend_act_q  <= tle_pkg::ACT_NEWLINE;
					pend_char_q <= tle_pkg::CH_NL;
					pend_cnt_q  <= '0;
					pend_last_q <= 1'b0;
					after_q     <= (wlen_q != '0) ? S_CP_RD : S_PUT;
					state_q     <= S_EMIT;
				end
				S_CP_RD: state_q <= S_CP_WR;
				S_CP_WR: begin
					pend_act_q  <= tle_pkg::ACT_ECHO;
					pend_char_q <= ram_rdata;
					pend_cnt_q  <= '0;
					pend_last_q <= 1'b0;
					k_q         <= k_q + LW'(1);
					after_q     <= ((k_q + LW'(1)) == wlen_q) ? S_PUT : S_CP_RD;
					state_q     <= S_EMIT;
				end
				S_PUT: begin
					len_q       <= wlen_q + LW'(1);
					pend_act_q  <= tle_pkg::ACT_ECHO;
					pend_char_q <= c_q;
					pend_cnt_q  <= '0;
					pend_last_q <= 1'b1;
					after_q     <= S_IDLE;
					state_q     <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign key.ready        = (state_q == S_IDLE);
	assign echo.valid       = ov_q;
	assign echo.action      = oact_q;
	assign echo.out_char    = ochar_q;
	assign echo.erase_count = ocnt_q;
	assign echo.last_of_run = olast_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(LINE_WIDTH))
		else $error("line length above line width");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WS_RD || state_q == S_WS_CHK || state_q == S_FS_RD ||
		 state_q == S_FS_CHK) |-> pos_q != '0)
		else $error("buffer scan at position zero");

	a_copy_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CP_RD || state_q == S_CP_WR) |-> k_q < wlen_q)
		else $error("word copy index past word length");

	a_erase_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oact_q == tle_pkg::ACT_ERASE) |-> ocnt_q != '0)
		else $error("erase beat with zero count");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && slot_free && pend_last_q) |=> state_q == S_IDLE)
		else $error("sequencer busy after final beat of a byte");

endmodule

`default_nettype wire

### verif/terminal_line_editor_wrap_core_test.sv
// ----------------------------------------------------------------------------
// Line editor with word wrap: self-checking testbench
// Types bytes into the editor, predicts the echo beats of each accepted byte
// and checks every echo beat field by field, under random stalls and with
// several settings of the erase and kill characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
	logic [tle_pkg::ACTION_W-1:0] action;
	logic [tle_pkg::CHAR_W-1:0]   out_char;
	logic [tle_pkg::COUNT_W-1:0]  erase_count;
	logic                         last_of_run;
} echo_beat_t;

typedef enum {WRAP_WORD, WRAP_SPACE_LAST, WRAP_NO_SPACE} wrap_kind_t;

class line_echo_board;
	localparam int LINE_W = tle_pkg::LINE_WIDTH_DEF;

	logic [tle_pkg::CHAR_W-1:0] line_buf [LINE_W];
	int                         line_len;
	logic [tle_pkg::CHAR_W-1:0] erase_code;
	logic [tle_pkg::CHAR_W-1:0] kill_code;
	echo_beat_t                 pending [$];
	int                         mismatches;
	int                         beats_checked;
	int                         keys_noted;
	int                         wraps_moved;
	int                         wraps_spaced;
	int                         wraps_bare;

	function new();
		line_len = 0;
		erase_code = tle_pkg::ERASE_CHAR_RST;
		kill_code = tle_pkg::KILL_CHAR_RST;
	endfunction

	task report(input string msg);
		if (mismatches < 40) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	function void set_reg(input logic idx, input logic [tle_pkg::CHAR_W-1:0] val);
		if (idx == tle_pkg::REG_ERASE_CHAR) begin
			erase_code = val;
		end else begin
			kill_code = val;
		end
	endfunction

	function void add_beat(input logic [tle_pkg::ACTION_W-1:0] act,
		input logic [tle_pkg::CHAR_W-1:0] ch, input int cnt);
		echo_beat_t b;
		b.action = act;
		b.out_char = ch;
		b.erase_count = tle_pkg::COUNT_W'(cnt);
		b.last_of_run = 1'b0;
		pending.push_back(b);
	endfunction

	// Works out the echo beats of one accepted byte and updates the line.
	function void note_key(input logic [tle_pkg::CHAR_W-1:0] code);
		int first;
		int cnt;
		int start;
		int wlen;
		bit found;
		first = pending.size();
		keys_noted++;
		if (code == tle_pkg::CH_EOT && line_len == 0) begin
			add_beat(tle_pkg::ACT_END, tle_pkg::CH_NUL, 0);
		end else if (code == tle_pkg::CH_WERASE) begin
			cnt = 0;
			while (line_len > 0 && line_buf[line_len-1] == tle_pkg::CH_SPACE) begin
				line_len--;
				cnt++;
			end
			while (line_len > 0 && line_buf[line_len-1] != tle_pkg::CH_SPACE) begin
				line_len--;
				cnt++;
			end
			if (cnt > 0) add_beat(tle_pkg::ACT_ERASE, tle_pkg::CH_NUL, cnt);
		end else if (code == tle_pkg::CH_NL) begin
			line_len = 0;
			add_beat(tle_pkg::ACT_NEWLINE, tle_pkg::CH_NL, 0);
		end else if (code == kill_code) begin
			if (line_len > 0) begin
				add_beat(tle_pkg::ACT_ERASE, tle_pkg::CH_NUL, line_len);
				line_len = 0;
			end
		end else if (code == erase_code) begin
			if (line_len > 0) begin
				line_len--;
				add_beat(tle_pkg::ACT_ERASE, tle_pkg::CH_NUL, 1);
			end
		end else if (code < tle_pkg::CH_SPACE || code > tle_pkg::CH_TILDE) begin
			add_beat(tle_pkg::ACT_BELL, tle_pkg::CH_BELL, 0);
		end else begin
			if (line_len >= LINE_W) begin
				// The line is full: the word after the last space moves down.
				found = 1'b0;
				start = 0;
				for (int i = LINE_W - 1; i >= 0 && !found; i--) begin
					if (line_buf[i] == tle_pkg::CH_SPACE) begin
						found = 1'b1;
						start = i + 1;
					end
				end
				if (found) begin
					wlen = LINE_W - start;
					if (wlen > 0) begin
						add_beat(tle_pkg::ACT_ERASE, tle_pkg::CH_NUL, wlen);
						wraps_moved++;
					end else begin
						wraps_spaced++;
					end
					add_beat(tle_pkg::ACT_NEWLINE, tle_pkg::CH_NL, 0);
					for (int k = 0; k < wlen; k++) begin
						line_buf[k] = line_buf[start+k];
						add_beat(tle_pkg::ACT_ECHO, line_buf[k], 0);
					end
					line_len = wlen;
				end else begin
					add_beat(tle_pkg::ACT_NEWLINE, tle_pkg::CH_NL, 0);
					line_len = 0;
					wraps_bare++;
				end
			end
			line_buf[line_len] = code;
			line_len++;
			add_beat(tle_pkg::ACT_ECHO, code, 0);
		end
		if (pending.size() > first) pending[pending.size()-1].last_of_run = 1'b1;
	endfunction

	task check_echo(input logic [tle_pkg::ACTION_W-1:0] act,
		input logic [tle_pkg::CHAR_W-1:0] ch, input logic [tle_pkg::COUNT_W-1:0] cnt,
		input logic last);
		echo_beat_t want;
		beats_checked++;
		if (pending.size() == 0) begin
			report($sformatf("beat %0d arrived with nothing expected (action %0d char %0d)",
				beats_checked, act, ch));
		end else begin
			want = pending.pop_front();
			if (act !== want.action)
				report($sformatf("beat %0d: action %0d, expected %0d",
					beats_checked, act, want.action));
			if (ch !== want.out_char)
				report($sformatf("beat %0d: out_char %0d, expected %0d",
					beats_checked, ch, want.out_char));
			if (cnt !== want.erase_count)
				report($sformatf("beat %0d: erase_count %0d, expected %0d",
					beats_checked, cnt, want.erase_count));
			if (last !== want.last_of_run)
				report($sformatf("beat %0d: last_of_run %0b, expected %0b",
					beats_checked, last, want.last_of_run));
		end
	endtask

	task flush_leftover();
		if (pending.size() != 0) begin
			report($sformatf("%0d expected beats never arrived", pending.size()));
			pending.delete();
		end
	endtask
endclass

module terminal_line_editor_wrap_core_test;

	localparam int LINE_W         = tle_pkg::LINE_WIDTH_DEF;
	localparam int SETTLE         = 5 * LINE_W + 60;
	localparam int DRAIN_MAX      = 20000;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int KEYS_PER_PHASE = 2;

	localparam logic [tle_pkg::PADDR_W-1:0] ADDR_ERASE =
		tle_pkg::PADDR_W'(tle_pkg::REG_ERASE_CHAR) << tle_pkg::REG_SEL_BIT;
	localparam logic [tle_pkg::PADDR_W-1:0] ADDR_KILL  =
		tle_pkg::PADDR_W'(tle_pkg::REG_KILL_CHAR) << tle_pkg::REG_SEL_BIT;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [tle_pkg::PADDR_W-1:0] paddr;
	logic [tle_pkg::PDATA_W-1:0] pwdata;
	logic [tle_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	logic                        echo_ready = 1'b0;

	line_echo_board board;
	int             keys_sent = 0;
	int             reg_writes = 0;
	int             cycle_count = 0;
	int             stall_left = 0;
	bit             idle_on = 1'b1;
	bit             stall_on = 1'b1;

	tle_key_if  key_ch();
	tle_echo_if echo_ch();

	assign echo_ch.ready = echo_ready;

	terminal_line_editor_wrap_core #(.LINE_WIDTH(LINE_W)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (key_ch),
		.echo    (echo_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d beats still expected",
				board.pending.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Echo side: check each accepted beat, then decide ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && echo_ch.valid && echo_ch.ready)
			board.check_echo(echo_ch.action, echo_ch.out_char, echo_ch.erase_count,
				echo_ch.last_of_run);
		if (stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 3);
		if (stall_left > 0) begin
			echo_ready <= 1'b0;
			stall_left--;
		end else begin
			echo_ready <= 1'b1;
		end
	end

	function automatic logic [tle_pkg::CHAR_W-1:0] rand_glyph();
		logic [tle_pkg::CHAR_W-1:0] c;
		do c = tle_pkg::CHAR_W'($urandom_range(33, 126));
		while (c == board.erase_code || c == board.kill_code);
		return c;
	endfunction

	task automatic send_key(input logic [tle_pkg::CHAR_W-1:0] code);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			key_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.in_char <= code;
		do @(posedge clk); while (!key_ch.ready);
		board.note_key(code);
		keys_sent++;
	endtask

	// Fills the line to the brim and types one more printable byte.
	task automatic wrap_line(input wrap_kind_t kind);
		if (kind == WRAP_NO_SPACE) begin
			send_key(tle_pkg::CH_NL);
			while (board.line_len < LINE_W) send_key(rand_glyph());
		end else begin
			while (board.line_len < LINE_W - 1)
				send_key(($urandom_range(0, 5) == 0) ? tle_pkg::CH_SPACE : rand_glyph());
			send_key((kind == WRAP_SPACE_LAST) ? tle_pkg::CH_SPACE : rand_glyph());
		end
		send_key(rand_glyph());
	endtask

	// Mostly words and spaces, with edits, controls and stray bytes mixed in.
	task automatic type_random(input int n_keys);
		int goal;
		int r;
		goal = keys_sent + n_keys;
		while (keys_sent < goal) begin
			r = $urandom_range(0, 99);
			if (board.line_len >= 24 && r < 15) begin
				wrap_line(wrap_kind_t'($urandom_range(0, 2)));
			end else if (r < 50) begin
				repeat ($urandom_range(1, 10)) send_key(rand_glyph());
				send_key(tle_pkg::CH_SPACE);
				if ($urandom_range(0, 4) == 0) send_key(tle_pkg::CH_SPACE);
			end else if (r < 55) begin
				send_key(tle_pkg::CH_NL);
			end else if (r < 59) begin
				send_key(board.kill_code);
			end else if (r < 67) begin
				repeat ($urandom_range(1, 3)) send_key(board.erase_code);
			end else if (r < 74) begin
				send_key(tle_pkg::CH_WERASE);
			end else if (r < 78) begin
				send_key(tle_pkg::CH_EOT);
			end else if (r < 92) begin
				send_key(tle_pkg::CHAR_W'($urandom_range(0, 255)));
			end else begin
				send_key(tle_pkg::CHAR_W'($urandom_range(0, 31)));
			end
		end
	endtask

	// Hold the keys back until every expected beat is in, then let the
	// sequencer finish any byte that produces no beat.
	task automatic wait_drained();
		int waited;
		key_ch.valid <= 1'b0;
		waited = 0;
		while (board.pending.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		board.flush_leftover();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [tle_pkg::CHAR_W-1:0] val);
		logic [tle_pkg::CHAR_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (idx == tle_pkg::REG_ERASE_CHAR) ? ADDR_ERASE : ADDR_KILL;
		pwdata <= tle_pkg::PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, val);
		reg_writes++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata[tle_pkg::CHAR_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (readback !== val)
			board.report($sformatf("register %0d reads %0d, written %0d", idx, readback, val));
	endtask

	task automatic config_phase(input logic [tle_pkg::CHAR_W-1:0] erase_val,
		input logic [tle_pkg::CHAR_W-1:0] kill_val);
		wait_drained();
		write_reg(tle_pkg::REG_ERASE_CHAR, erase_val);
		write_reg(tle_pkg::REG_KILL_CHAR, kill_val);
		type_random(KEYS_PER_PHASE);
	endtask

	initial begin
		key_ch.valid <= 1'b0;
		key_ch.in_char <= tle_pkg::CH_NUL;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes at the reset settings, starting on an empty line.
		send_key(tle_pkg::CH_EOT);
		send_key(tle_pkg::ERASE_CHAR_RST);
		send_key(tle_pkg::KILL_CHAR_RST);
		send_key(tle_pkg::CH_WERASE);
		send_key(tle_pkg::CH_NUL);
		send_key(8'hFF);
		send_key(8'h80);
		send_key(8'h1F);
		send_key(tle_pkg::CH_SPACE);
		send_key(tle_pkg::CH_TILDE);
		send_key("a");
		send_key(tle_pkg::CH_EOT);
		send_key(tle_pkg::ERASE_CHAR_RST);
		send_key("b");
		send_key("c");
		send_key(tle_pkg::CH_SPACE);
		send_key(tle_pkg::CH_SPACE);
		send_key(tle_pkg::CH_WERASE);
		send_key(tle_pkg::CH_WERASE);
		send_key("x");
		send_key("y");
		send_key(tle_pkg::KILL_CHAR_RST);
		send_key("z");
		send_key(tle_pkg::CH_NL);

		// A wrapped word of LINE_W - 2 characters, then a wrap right after a space,
		// then a full line with no space at all.
		send_key(rand_glyph());
		send_key(tle_pkg::CH_SPACE);
		repeat (LINE_W - 2) send_key(rand_glyph());
		send_key(rand_glyph());
		send_key(tle_pkg::CH_SPACE);
		send_key(rand_glyph());
		repeat (LINE_W - 1) send_key(rand_glyph());
		send_key(rand_glyph());

		config_phase(8'h00, 8'hFF);
		config_phase(8'hFF, 8'h00);
		// A printable erase character, and a kill character hidden by word erase.
		config_phase("a", tle_pkg::CH_WERASE);
		config_phase(tle_pkg::CH_NL, tle_pkg::CH_EOT);
		// Kill takes precedence when both registers hold the same byte.
		config_phase(8'h08, 8'h08);

		idle_on = 1'b0;
		stall_on = 1'b0;
		config_phase(tle_pkg::ERASE_CHAR_RST, tle_pkg::KILL_CHAR_RST);
		wait_drained();

		$display("Covered %0d typed bytes, %0d echo beats and %0d register writes.",
			board.keys_noted, board.beats_checked, reg_writes);
		$display("Wraps: %0d moved a word, %0d ended on a space, %0d had no space.",
			board.wraps_moved, board.wraps_spaced, board.wraps_bare);
		if (board.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
